### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; every macro reports through $error
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`endif

### rtl/idi_pkg.sv
// shared types, widths and calibration rom for the ir distance interpolator
// no dependencies
`default_nettype none

package idi_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned DIST_W         = 12;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned X_W            = 12;
  localparam int unsigned ROM_SIZE       = 27;
  localparam int unsigned ROM_IDX_W      = $clog2(ROM_SIZE + 1);
  localparam int unsigned NUM_POINTS_DEF = 27;
  localparam int unsigned NUM_W          = 2 * DIST_W;
  localparam int unsigned ALU_W          = NUM_W + 1;
  localparam int unsigned DIV_STEPS      = DIST_W;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [STATUS_W-1:0] {
    RANGE_IN   = 2'd0,
    RANGE_NEAR = 2'd1,
    RANGE_FAR  = 2'd2
  } range_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

  // breakpoint x values, falling
  function automatic logic [X_W-1:0] rom_x(input logic [ROM_IDX_W-1:0] idx);
    logic [X_W-1:0] v;
    unique case (idx)
      5'd0:    v = 12'd2336;
      5'd1:    v = 12'd2014;
      5'd2:    v = 12'd1818;
      5'd3:    v = 12'd1612;
      5'd4:    v = 12'd1458;
      5'd5:    v = 12'd1312;
      5'd6:    v = 12'd1211;
      5'd7:    v = 12'd1114;
      5'd8:    v = 12'd1041;
      5'd9:    v = 12'd968;
      5'd10:   v = 12'd894;
      5'd11:   v = 12'd842;
      5'd12:   v = 12'd792;
      5'd13:   v = 12'd743;
      5'd14:   v = 12'd696;
      5'd15:   v = 12'd671;
      5'd16:   v = 12'd621;
      5'd17:   v = 12'd596;
      5'd18:   v = 12'd546;
      5'd19:   v = 12'd522;
      5'd20:   v = 12'd495;
      5'd21:   v = 12'd471;
      5'd22:   v = 12'd469;
      5'd23:   v = 12'd445;
      5'd24:   v = 12'd420;
      5'd25:   v = 12'd395;
      5'd26:   v = 12'd390;
      default: v = '0;
    endcase
    return v;
  endfunction

  // breakpoint distances, q4.8, 2.0 up in half steps
  function automatic logic [DIST_W-1:0] rom_d(input logic [ROM_IDX_W-1:0] idx);
    logic [DIST_W-1:0] v;
    if (idx < ROM_IDX_W'(ROM_SIZE)) begin
      v = DIST_W'(12'd512 + {idx, 7'd0});
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/idi_alu.sv
// shared subtract / compare unit of the interpolator sequencer
// depends on idi_pkg
`default_nettype none

module idi_alu (
  input  wire logic [idi_pkg::ALU_W-1:0] a,
  input  wire logic [idi_pkg::ALU_W-1:0] b,
  output idi_pkg::alu_res_t              res
);
  import idi_pkg::*;

  logic [ALU_W:0] wide;

  // borrow set means b > a
  assign wide       = {1'b0, a} - {1'b0, b};
  assign res.diff   = wide[ALU_W-1:0];
  assign res.borrow = wide[ALU_W];

endmodule

`default_nettype wire

### rtl/ir_distance_interpolator.sv
// ir distance interpolator top level: rom scan, interpolation, serial divide
// depends on idi_pkg and idi_alu
`default_nettype none

//  channel   ports                                   direction
//  in        in_valid, in_ready, in_sample           sample transfer into the block
//  out       out_valid, out_ready, out_distance,     result transfer out of the block
//            out_range_status
//
//  a sample runs through the rom scan (one breakpoint a cycle) and, unless it is
//  clamped at either end, the 12-step restoring divide through the shared subtractor
//  in_ready is high only while the sequencer is idle; a new sample is taken while
//  the previous result still waits in the output register
//  reset (synchronous, active low) clears the sequencer and output valid only

module ir_distance_interpolator #(
  parameter int unsigned NUM_POINTS = idi_pkg::NUM_POINTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [idi_pkg::SAMPLE_W-1:0]  in_sample,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [idi_pkg::DIST_W-1:0]    out_distance,
  output      logic [idi_pkg::STATUS_W-1:0]  out_range_status
);
  import idi_pkg::*;

  // breakpoints actually used, clipped to the range 1 to ROM_SIZE
  localparam int unsigned USED  = (NUM_POINTS > ROM_SIZE) ? ROM_SIZE :
                                  ((NUM_POINTS < 1) ? 1 : NUM_POINTS);
  localparam int unsigned IDX_W = $clog2(USED + 1);
  localparam logic [IDX_W-1:0]     IDX_END  = IDX_W'(USED);
  localparam logic [ROM_IDX_W-1:0] LAST_IDX = ROM_IDX_W'(USED - 1);

  state_t                state_r, state_nxt;
  logic [SAMPLE_W-1:0]   sample_r, sample_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [X_W-1:0]        dx_r, dx_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [ALU_W-1:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0]      dsh_r, dsh_nxt;
  logic [DIST_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIST_W-1:0]     res_dist_r, res_dist_nxt;
  range_t                res_status_r, res_status_nxt;
  logic [DIST_W-1:0]     out_dist_r, out_dist_nxt;
  range_t                out_status_r, out_status_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [ALU_W-1:0]      alu_a, alu_b;
  alu_res_t              alu_res;

  logic [ROM_IDX_W-1:0]  cur_idx, prev_idx;
  logic [X_W-1:0]        cur_x, prev_x, den;
  logic [DIST_W-1:0]     prev_d, dy;

  // current and previous breakpoint
  assign cur_idx  = ROM_IDX_W'(idx_r);
  assign prev_idx = ROM_IDX_W'(idx_r - IDX_W'(1));
  assign cur_x    = rom_x(cur_idx);
  assign prev_x   = rom_x(prev_idx);
  assign prev_d   = rom_d(prev_idx);
  assign dy       = rom_d(cur_idx) - prev_d;
  assign den      = prev_x - cur_x;

  idi_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r     <= sample_nxt;
    idx_r        <= idx_nxt;
    dx_r         <= dx_nxt;
    num_r        <= num_nxt;
    rem_r        <= rem_nxt;
    dsh_r        <= dsh_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    res_dist_r   <= res_dist_nxt;
    res_status_r <= res_status_nxt;
    out_dist_r   <= out_dist_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    idx_nxt        = idx_r;
    dx_nxt         = dx_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    dsh_nxt        = dsh_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    res_dist_nxt   = res_dist_r;
    res_status_nxt = res_status_r;
    out_dist_nxt   = out_dist_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    alu_a          = '0;
    alu_b          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          idx_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end

      // one breakpoint a cycle: borrow means its x is above the sample
      ST_SCAN: begin
        alu_a = ALU_W'(sample_r);
        alu_b = ALU_W'(cur_x);
        priority if (idx_r == IDX_END) begin
          // below the last used breakpoint: far clamp
          res_dist_nxt   = rom_d(LAST_IDX);
          res_status_nxt = RANGE_FAR;
          state_nxt      = ST_RESULT;
        end else if (alu_res.borrow) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else if (idx_r == '0) begin
          // at or above the first breakpoint
          res_dist_nxt   = rom_d('0);
          res_status_nxt = (alu_res.diff != '0) ? RANGE_NEAR : RANGE_IN;
          state_nxt      = ST_RESULT;
        end else begin
          state_nxt = ST_SETUP;
        end
      end

      // x1 - sample, at most x1 - x2 so it fits the x width
      ST_SETUP: begin
        alu_a     = ALU_W'(prev_x);
        alu_b     = ALU_W'(sample_r);
        dx_nxt    = alu_res.diff[X_W-1:0];
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        num_nxt   = NUM_W'(dy * dx_r);
        state_nxt = ST_LOAD;
      end

      // dividend 2*num + den, divisor 2*den aligned to the top quotient bit
      ST_LOAD: begin
        rem_nxt   = {num_r, 1'b0} + ALU_W'(den);
        dsh_nxt   = {den, {(NUM_W - X_W){1'b0}}};
        quo_nxt   = '0;
        cnt_nxt   = DIV_CNT_W'(DIV_STEPS - 1);
        state_nxt = ST_DIV;
      end

      // restoring divide, one quotient bit a cycle
      ST_DIV: begin
        alu_a   = rem_r;
        alu_b   = ALU_W'(dsh_r);
        quo_nxt = {quo_r[DIST_W-2:0], !alu_res.borrow};
        if (!alu_res.borrow) begin
          rem_nxt = alu_res.diff;
        end
        dsh_nxt = dsh_r >> 1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - DIV_CNT_W'(1);
        end
      end

      ST_FIN: begin
        res_dist_nxt   = prev_d + quo_r;
        res_status_nxt = RANGE_IN;
        state_nxt      = ST_RESULT;
      end

      // wait for the output register to free up
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_dist_nxt   = res_dist_r;
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_distance     = out_dist_r;
  assign out_range_status = out_status_r;

endmodule

`default_nettype wire

### rtl/idi_checker.sv
// port-level checks for the ir distance interpolator, bound to the top level
// depends on assert_macros.svh and idi_pkg
`default_nettype none

`include "assert_macros.svh"

module idi_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [idi_pkg::DIST_W-1:0]    out_distance,
  input wire logic [idi_pkg::STATUS_W-1:0]  out_range_status
);
  import idi_pkg::*;

  // stalled result holds
  `ASSERT_PROP(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_distance) && $stable(out_range_status)))

  // sequencer is busy right after taking a sample
  `ASSERT_PROP(a_busy_after_in, clk, rst_n, (in_valid && in_ready) |=> !in_ready)

  // distance stays within the table span
  `ASSERT_NEVER(a_dist_span, clk, rst_n, out_valid && (out_distance < DIST_W'(512) || out_distance > DIST_W'(3840)))

  // near clamp gives the first distance, no status above the far clamp shows
  `ASSERT_NEVER(a_near_clamp, clk, rst_n, out_valid && ((out_range_status == RANGE_NEAR && out_distance != DIST_W'(512)) || out_range_status > RANGE_FAR))

endmodule

bind ir_distance_interpolator idi_checker u_idi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_distance     (out_distance),
  .out_range_status (out_range_status)
);

`default_nettype wire
